>>> src/wavetable_oscillator_unit_macros.svh
// Assertion macros shared by the wavetable oscillator RTL.
`ifndef WAVETABLE_OSCILLATOR_UNIT_MACROS_SVH
`define WAVETABLE_OSCILLATOR_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WTO_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define WTO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/wto_pkg.sv
// Types, constants and table functions of the wavetable oscillator.
`default_nettype none

package wto_pkg;

  // The table length must be a power of two so that the phase wraps by truncation.
  localparam int TABLE_LENGTH  = 256;
  localparam int FRACTION_BITS = 16;
  localparam int INDEX_W       = $clog2(TABLE_LENGTH);
  localparam int PHASE_W       = INDEX_W + FRACTION_BITS;

  localparam int FUNC_W   = 2;
  localparam int AMOUNT_W = 25;
  localparam int RATE_W   = 25;
  localparam int OFFSET_W = 26;
  localparam int SAMPLE_W = 16;
  localparam int ENTRY_W  = SAMPLE_W + 1;
  localparam int DIFF_W   = ENTRY_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = OFFSET_W;

  localparam logic [FUNC_W-1:0] FUNC_TICK    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_ADVANCE = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_WAVE_TYPE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE         = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PHASE_OFFSET = 2'd2;

  localparam logic signed [RATE_W-1:0] RATE_RESET = RATE_W'(65536);

  localparam longint HALF_PI_Q30 = 64'sd1686629713;

  typedef logic [FUNC_W-1:0]          func_t;
  typedef logic signed [AMOUNT_W-1:0] amount_t;
  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [ENTRY_W-1:0]  entry_t;
  typedef logic [PHASE_W-1:0]         phase_t;

  typedef struct packed {
    logic                       wave_type;
    logic signed [RATE_W-1:0]   rate;
    logic signed [OFFSET_W-1:0] phase_offset;
  } wto_cfg_t;

  typedef struct packed {
    func_t  func;
    phase_t phase;
  } wto_s1_t;

  typedef struct packed {
    func_t                    func;
    entry_t                   base;
    logic signed [DIFF_W-1:0] diff;
    logic [FRACTION_BITS-1:0] frac;
  } wto_s2_t;

  // Sine of a Q30 angle in the first quadrant, as a Q30 value.
  // The series runs to the fifteenth power; each divisor is the next pair of factorial terms.
  function automatic longint sin_q30(longint x);
    longint x2;
    longint term;
    longint sum;
    x2   = (x * x) >>> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >>> 30) / 64'sd6;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 64'sd20;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 64'sd42;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 64'sd72;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 64'sd110;
    sum  = sum - term;
    term = ((term * x2) >>> 30) / 64'sd156;
    sum  = sum + term;
    term = ((term * x2) >>> 30) / 64'sd210;
    sum  = sum - term;
    return sum;
  endfunction

  function automatic entry_t sine_entry(int i);
    longint n;
    longint quad;
    longint rem;
    longint x;
    longint s;
    longint q15;
    n    = longint'(i) * 4;
    quad = n / TABLE_LENGTH;
    rem  = n % TABLE_LENGTH;
    x    = (rem * HALF_PI_Q30) / TABLE_LENGTH;
    if ((quad & 1) != 0) begin
      x = HALF_PI_Q30 - x;
    end
    s = sin_q30(x);
    if (s < 0) begin
      s = 0;
    end
    q15 = (s + 16384) >>> 15;
    if (q15 > 32768) begin
      q15 = 32768;
    end
    if ((quad & 2) != 0) begin
      q15 = -q15;
    end
    return ENTRY_W'(q15);
  endfunction

  function automatic entry_t saw_entry(int i);
    longint v;
    v = (longint'(i) * 32768 + TABLE_LENGTH / 2) / TABLE_LENGTH;
    return ENTRY_W'(v);
  endfunction

endpackage

`default_nettype wire

>>> src/wto_if.sv
// Stream interfaces for the oscillator's command input and sample output.
`default_nettype none

interface wto_in_if import wto_pkg::*; ();
  logic    valid;
  logic    ready;
  func_t   func;
  amount_t amount;

  modport source (output valid, output func, output amount, input ready);
  modport sink   (input valid, input func, input amount, output ready);
endinterface

interface wto_out_if import wto_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

`default_nettype wire

>>> src/wto_phase.sv
// Phase accumulator and input register of the oscillator.
`default_nettype none

module wto_phase import wto_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic signed [RATE_W-1:0] rate,
  wto_in_if.sink                        in_if,
  output logic                          s1_valid,
  output wto_s1_t                       s1_data,
  input  wire logic                     s1_ready
);

  phase_t  phase_r;
  phase_t  phase_nxt;
  logic    s1_valid_r;
  wto_s1_t s1_data_r;
  logic    accept;

  assign in_if.ready = !s1_valid_r || s1_ready;
  assign accept      = in_if.valid && in_if.ready;

  // Truncating the signed sum wraps the phase modulo the table length.
  always_comb begin
    unique case (in_if.func)
      FUNC_TICK:    phase_nxt = phase_r + PHASE_W'(rate);
      FUNC_CLEAR:   phase_nxt = '0;
      FUNC_ADVANCE: phase_nxt = phase_r + PHASE_W'(in_if.amount);
      default:      phase_nxt = phase_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= '0;
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      phase_r    <= phase_nxt;
      s1_valid_r <= 1'b1;
    end else if (s1_ready) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_data_r.func  <= in_if.func;
      s1_data_r.phase <= phase_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_data  = s1_data_r;

endmodule

`default_nettype wire

>>> src/wto_lookup.sv
// Read point, table lookup and neighbour difference of the oscillator.
`default_nettype none

module wto_lookup import wto_pkg::*; (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       wave_type,
  input  wire logic signed [OFFSET_W-1:0] phase_offset,
  input  wire logic                       s1_valid,
  input  wire wto_s1_t                    s1_data,
  output logic                            s1_ready,
  output logic                            s2_valid,
  output wto_s2_t                         s2_data,
  input  wire logic                       s2_ready
);

  entry_t               sine_rom [TABLE_LENGTH];
  entry_t               saw_rom  [TABLE_LENGTH];
  phase_t               pos;
  logic [INDEX_W-1:0]   idx;
  logic [INDEX_W-1:0]   idx_next;
  entry_t               entry_a;
  entry_t               entry_b;
  logic                 s2_valid_r;
  wto_s2_t              s2_data_r;
  logic                 take;

  for (genvar g = 0; g < TABLE_LENGTH; g++) begin : g_rom
    assign sine_rom[g] = sine_entry(g);
    assign saw_rom[g]  = saw_entry(g);
  end

  // The upper neighbour of the last entry is the first entry again.
  assign pos      = s1_data.phase + PHASE_W'(phase_offset);
  assign idx      = pos[PHASE_W-1:FRACTION_BITS];
  assign idx_next = idx + INDEX_W'(1);
  assign entry_a  = wave_type ? saw_rom[idx]      : sine_rom[idx];
  assign entry_b  = wave_type ? saw_rom[idx_next] : sine_rom[idx_next];

  assign s1_ready = !s2_valid_r || s2_ready;
  assign take     = s1_valid && s1_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else if (take) begin
      s2_valid_r <= 1'b1;
    end else if (s2_ready) begin
      s2_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s2_data_r.func <= s1_data.func;
      s2_data_r.base <= entry_a;
      s2_data_r.diff <= DIFF_W'(entry_b) - DIFF_W'(entry_a);
      s2_data_r.frac <= pos[FRACTION_BITS-1:0];
    end
  end

  assign s2_valid = s2_valid_r;
  assign s2_data  = s2_data_r;

endmodule

`default_nettype wire

>>> src/wto_interp.sv
// Interpolation, saturation and result register of the oscillator.
`default_nettype none

module wto_interp import wto_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    s2_valid,
  input  wire wto_s2_t s2_data,
  output logic         s2_ready,
  wto_out_if.source    out_if
);

  localparam int PROD_W = DIFF_W + FRACTION_BITS + 1;
  localparam int SUM_W  = PROD_W + 1;
  localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1) << (FRACTION_BITS - 1);
  localparam logic signed [SUM_W-1:0]  SAT_HI = SUM_W'((1 << (SAMPLE_W - 1)) - 1);
  localparam logic signed [SUM_W-1:0]  SAT_LO = -SAT_HI - SUM_W'(1);

  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rounded;
  logic signed [PROD_W-1:0] shifted;
  logic signed [SUM_W-1:0]  interp;
  sample_t                  clipped;
  sample_t                  sample_r;
  sample_t                  sample_nxt;
  logic                     out_valid_r;
  logic                     take;

  // Adding half before the arithmetic shift rounds to nearest, with ties towards plus infinity.
  assign prod    = s2_data.diff * $signed({1'b0, s2_data.frac});
  assign rounded = prod + ROUND_HALF;
  assign shifted = rounded >>> FRACTION_BITS;
  assign interp  = SUM_W'(s2_data.base) + SUM_W'(shifted);

  always_comb begin
    priority if (interp > SAT_HI) begin
      clipped = SAT_HI[SAMPLE_W-1:0];
    end else if (interp < SAT_LO) begin
      clipped = SAT_LO[SAMPLE_W-1:0];
    end else begin
      clipped = interp[SAMPLE_W-1:0];
    end
  end

  always_comb begin
    unique case (s2_data.func)
      FUNC_TICK:  sample_nxt = clipped;
      FUNC_CLEAR: sample_nxt = '0;
      default:    sample_nxt = sample_r;
    endcase
  end

  assign s2_ready = !out_valid_r || out_if.ready;
  assign take     = s2_valid && s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sample_r    <= '0;
    end else if (take) begin
      out_valid_r <= 1'b1;
      sample_r    <= sample_nxt;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_if.valid  = out_valid_r;
  assign out_if.sample = sample_r;

endmodule

`default_nettype wire

>>> src/wavetable_oscillator_unit.sv
// Top level of the looping wavetable oscillator with linear interpolation.
//
//   channel  direction  transfer when          payload
//   in_if    sink       in_if.valid & ready    func, amount
//   out_if   source     out_if.valid & ready   sample
//   cfg_*    write      cfg_we                 cfg_index, cfg_data
//
// One item is accepted per cycle while the output is not stalled; its sample passes the first-stage,
// second-stage and result registers. The phase accumulator updates on every input transfer, which sets the item rate.
// Reset is synchronous: it clears the phase, the last sample and all stage valids.
// A waiting result holds the stages behind it; input is still taken until the first is full.
`default_nettype none

`include "wavetable_oscillator_unit_macros.svh"

module wavetable_oscillator_unit import wto_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  wto_in_if.sink                     in_if,
  wto_out_if.source                  out_if,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  wto_cfg_t cfg_r;
  logic     s1_valid;
  wto_s1_t  s1_data;
  logic     s1_ready;
  logic     s2_valid;
  wto_s2_t  s2_data;
  logic     s2_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wave_type    <= 1'b0;
      cfg_r.rate         <= RATE_RESET;
      cfg_r.phase_offset <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WAVE_TYPE:    cfg_r.wave_type    <= cfg_data[0];
        CFG_RATE:         cfg_r.rate         <= cfg_data[RATE_W-1:0];
        CFG_PHASE_OFFSET: cfg_r.phase_offset <= cfg_data[OFFSET_W-1:0];
        default: ;
      endcase
    end
  end

  wto_phase u_phase (
    .clk      (clk),
    .rst_n    (rst_n),
    .rate     (cfg_r.rate),
    .in_if    (in_if),
    .s1_valid (s1_valid),
    .s1_data  (s1_data),
    .s1_ready (s1_ready)
  );

  wto_lookup u_lookup (
    .clk          (clk),
    .rst_n        (rst_n),
    .wave_type    (cfg_r.wave_type),
    .phase_offset (cfg_r.phase_offset),
    .s1_valid     (s1_valid),
    .s1_data      (s1_data),
    .s1_ready     (s1_ready),
    .s2_valid     (s2_valid),
    .s2_data      (s2_data),
    .s2_ready     (s2_ready)
  );

  wto_interp u_interp (
    .clk      (clk),
    .rst_n    (rst_n),
    .s2_valid (s2_valid),
    .s2_data  (s2_data),
    .s2_ready (s2_ready),
    .out_if   (out_if)
  );

  `WTO_ASSERT_NEXT(a_clear_zeroes_sample, clk, rst_n, s2_valid && s2_ready && s2_data.func == FUNC_CLEAR, out_if.valid && out_if.sample == '0, "Clear item did not produce a zero sample")
  `WTO_ASSERT_NEXT(a_advance_holds_sample, clk, rst_n, s2_valid && s2_ready && s2_data.func == FUNC_ADVANCE, out_if.sample == $past(out_if.sample), "Advance item changed the sample")
  `WTO_ASSERT_SAME(a_empty_stage_ready, clk, rst_n, !s1_valid, in_if.ready, "Input not ready with an empty first stage")

endmodule

`default_nettype wire
